// ----- hdl/tsb_pkg.sv -----
// shared types and constants for the store buffer with load forwarding
// no dependencies; imported by tsb_cell and the top level
`default_nettype none

package tsb_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int ADDR_W = 32;
    localparam int SIZE_W = 4;
    localparam int DATA_W = 64;
    localparam int DU_W   = 5;
    localparam int MAX_SIZE = 8;

    typedef enum logic [2:0] {
        OP_STORE  = 3'd0,
        OP_LOAD   = 3'd1,
        OP_FENCE  = 3'd2,
        OP_DRAIN  = 3'd3,
        OP_ATOMIC = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_BUFFERED = 3'd0,
        ST_FORWARD  = 3'd1,
        ST_READ     = 3'd2,
        ST_STALL    = 3'd3,
        ST_WRITE    = 3'd4,
        ST_FULL     = 3'd5,
        ST_ERROR    = 3'd6
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [ADDR_W-1:0]  addr;
        logic [SIZE_W-1:0]  size;
        logic [DATA_W-1:0]  data;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [ADDR_W-1:0]  mem_addr;
        logic [SIZE_W-1:0]  mem_size;
        logic [DATA_W-1:0]  value;
        logic [DU_W-1:0]    drain_until;
        logic               wake;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [SIZE_W-1:0]  size;
        logic [DATA_W-1:0]  data;
    } t_entry;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [SIZE_W-1:0]  size;
    } t_query;

    typedef struct packed {
        logic shift;
        logic write;
        logic cmp;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- hdl/tsb_cell.sv -----
// one buffer slot: holds an entry, shifts toward the oldest end on drain,
// and registers its overlap and exact-match flags; uses tsb_pkg
`default_nettype none

module tsb_cell (
    input  wire logic               i_clk,
    input  wire tsb_pkg::t_cell_ctl i_ctl,
    input  wire tsb_pkg::t_entry    i_wr,
    input  wire tsb_pkg::t_entry    i_next,
    input  wire tsb_pkg::t_query    i_q,
    output tsb_pkg::t_entry         o_entry,
    output logic                    o_hit,
    output logic                    o_exact
);
    import tsb_pkg::*;

    t_entry             r_entry;
    logic               r_hit;
    logic               r_exact;
    logic [ADDR_W-1:0]  w_d_fwd;
    logic [ADDR_W-1:0]  w_d_bwd;
    logic               w_ovl;

    // wrapping byte-range overlap
    assign w_d_fwd = r_entry.addr - i_q.addr;
    assign w_d_bwd = i_q.addr - r_entry.addr;
    assign w_ovl   = (w_d_fwd < {{(ADDR_W-SIZE_W){1'b0}}, i_q.size})
                  || (w_d_bwd < {{(ADDR_W-SIZE_W){1'b0}}, r_entry.size});

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_entry <= i_next;
        end else if (i_ctl.write) begin
            r_entry <= i_wr;
        end
        if (i_ctl.cmp) begin
            r_hit   <= w_ovl;
            r_exact <= (r_entry.addr == i_q.addr) && (r_entry.size == i_q.size);
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;
    assign o_exact = r_exact;

endmodule

`default_nettype wire

// ----- hdl/tso_store_buffer_forwarding_core.sv -----
// top level: fifo store buffer with store-to-load forwarding
// built from a row of tsb_cell slots; uses tsb_pkg
// an accepted item passes the compare pass through the cell row (S_CMP) and the
//   newest-first select (S_FIN) before its result is registered; no new item is
//   taken until then, and a held result stalls the select
// reset: fill count, pending wait and control clear; slot contents are undefined
`default_nettype none

module tso_store_buffer_forwarding_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire tsb_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output tsb_pkg::t_out_item     o_out_item
);
    import tsb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_FIN
    } t_state;

    // control state
    t_state             r_state,   n_state;
    logic [CNT_W-1:0]   r_fill,    n_fill;
    logic [IDX_W-1:0]   r_wait,    n_wait;
    logic               r_wait_pend, n_wait_pend;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out,     n_out;

    // latched item, size clamped and data trimmed
    t_op                r_op;
    t_query             r_q;
    logic [DATA_W-1:0]  r_data;

    logic               w_accept;
    logic               w_fire;
    logic [SIZE_W-1:0]  w_sz;
    logic [DATA_W-1:0]  w_data;

    // cell row
    t_entry             w_entry [DEPTH];
    logic [DEPTH-1:0]   w_hit;
    logic [DEPTH-1:0]   w_exact;
    logic               w_shift;
    logic               w_store;
    t_entry             w_wr;

    // newest-first search result
    logic               w_found;
    logic [IDX_W-1:0]   w_k;
    logic [IDX_W-1:0]   w_lvl;
    logic [CNT_W-1:0]   w_fill_m1;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    // result register frees up when empty or taken this cycle
    assign w_fire     = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    // clamp size into 1..8 and clear bytes above it
    always_comb begin
        if (i_in_item.size == '0) begin
            w_sz = SIZE_W'(1);
        end else if (i_in_item.size > SIZE_W'(MAX_SIZE)) begin
            w_sz = SIZE_W'(MAX_SIZE);
        end else begin
            w_sz = i_in_item.size;
        end
        for (int j = 0; j < MAX_SIZE; j++) begin
            w_data[j*8 +: 8] = (SIZE_W'(j) < w_sz) ? i_in_item.data[j*8 +: 8] : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_in_item.op;
            r_q    <= '{addr: i_in_item.addr, size: w_sz};
            r_data <= w_data;
        end
    end

    // slot 0 holds the oldest entry; a drain shifts every slot down by one
    assign w_wr = '{addr: r_q.addr, size: r_q.size, data: r_data};

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            t_cell_ctl w_ctl;
            t_entry    w_next;

            assign w_ctl.shift = w_shift;
            assign w_ctl.write = w_store && (r_fill == CNT_W'(gi));
            assign w_ctl.cmp   = (r_state == S_CMP);

            if (gi < DEPTH - 1) begin : g_mid
                assign w_next = w_entry[gi+1];
            end else begin : g_end
                assign w_next = '0;
            end

            tsb_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_wr    (w_wr),
                .i_next  (w_next),
                .i_q     (r_q),
                .o_entry (w_entry[gi]),
                .o_hit   (w_hit[gi]),
                .o_exact (w_exact[gi])
            );
        end
    endgenerate

    // newest overlapping valid slot wins
    always_comb begin
        w_found = 1'b0;
        w_k     = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_hit[i] && (CNT_W'(i) < r_fill)) begin
                w_found = 1'b1;
                w_k     = IDX_W'(i);
            end
        end
    end

    // entries newer than the overlapping one
    assign w_lvl     = IDX_W'(r_fill - {{(CNT_W-IDX_W){1'b0}}, w_k} - CNT_W'(1));
    assign w_fill_m1 = r_fill - CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_wait      = r_wait;
        n_wait_pend = r_wait_pend;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_shift     = 1'b0;
        w_store     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (w_fire) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out       = '{status: ST_ERROR, default: '0};
                    unique case (r_op)
                        OP_STORE: begin
                            if (r_fill == CNT_W'(DEPTH)) begin
                                n_out.status      = ST_FULL;
                                n_out.drain_until = DU_W'(DEPTH - 1);
                                n_wait            = IDX_W'(DEPTH - 1);
                                n_wait_pend       = 1'b1;
                            end else begin
                                w_store      = 1'b1;
                                n_fill       = r_fill + CNT_W'(1);
                                n_out.status = ST_BUFFERED;
                            end
                        end
                        OP_LOAD: begin
                            if (!w_found) begin
                                n_out.status   = ST_READ;
                                n_out.mem_addr = r_q.addr;
                                n_out.mem_size = r_q.size;
                            end else if (w_exact[w_k]) begin
                                n_out.status = ST_FORWARD;
                                n_out.value  = w_entry[w_k].data;
                            end else begin
                                n_out.status      = ST_STALL;
                                n_out.drain_until = DU_W'(w_lvl);
                                n_wait            = w_lvl;
                                n_wait_pend       = 1'b1;
                            end
                        end
                        OP_FENCE: begin
                            if (r_fill != '0) begin
                                n_out.status = ST_STALL;
                                n_wait       = '0;
                                n_wait_pend  = 1'b1;
                            end else begin
                                n_out.status = ST_BUFFERED;
                            end
                        end
                        OP_DRAIN: begin
                            if (r_fill != '0) begin
                                w_shift        = 1'b1;
                                n_fill         = w_fill_m1;
                                n_out.status   = ST_WRITE;
                                n_out.mem_addr = w_entry[0].addr;
                                n_out.mem_size = w_entry[0].size;
                                n_out.value    = w_entry[0].data;
                                // wake the waiting access once the level is reached
                                if (r_wait_pend
                                    && (w_fill_m1 <= {{(CNT_W-IDX_W){1'b0}}, r_wait})) begin
                                    n_wait_pend = 1'b0;
                                    n_wait      = '0;
                                    n_out.wake  = 1'b1;
                                end
                            end
                        end
                        OP_ATOMIC: begin
                            if (r_fill == '0) begin
                                n_out.status   = ST_WRITE;
                                n_out.mem_addr = r_q.addr;
                                n_out.mem_size = r_q.size;
                                n_out.value    = r_data;
                            end
                        end
                        default: begin
                            n_out.status = ST_ERROR;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_wait      <= '0;
            r_wait_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_wait      <= n_wait;
            r_wait_pend <= n_wait_pend;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // fill count never passes the buffer depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    // a new result appears only out of the select cycle
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire) |=> (o_out_valid && $past(r_state == S_FIN)))
        else $error("result not loaded from select");

    // wake only rides on a drained memory write
    a_wake_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.wake) |-> (o_out_item.status == ST_WRITE))
        else $error("wake without memory write");

    // an accepted item moves on to the compare pass
    a_accept_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CMP))
        else $error("accepted item not compared");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// testbench for tso_store_buffer_forwarding_core: directed and random access streams
// every result item is checked against a shadow store buffer kept in a small class
// depends on tsb_pkg and the core rtl only

module tb_top;
    import tsb_pkg::*;

    // watchdog and run length
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1450;
    localparam int TAIL_CYCLES  = 12;

    // opcodes the block does not define, sent to hit the error path
    localparam logic [2:0] OP_RSVD_5 = 3'd5;
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

    // operation mixes for the random part
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_EVEN  = 2;

    // shadow copy of the store buffer; predicts one result item per access
    class store_buffer_shadow;
        logic [ADDR_W-1:0] slot_addr [DEPTH];
        logic [SIZE_W-1:0] slot_size [DEPTH];
        logic [DATA_W-1:0] slot_data [DEPTH];
        int unsigned       fill;
        int unsigned       head;
        int unsigned       wait_level;
        bit                wait_pending;
        int unsigned       errors;
        t_out_item         expected_responses [$];

        function new();
            fill         = 0;
            head         = 0;
            wait_level   = 0;
            wait_pending = 1'b0;
            errors       = 0;
        endfunction

        // byte ranges wrap around the top of the address space
        function bit overlaps(logic [ADDR_W-1:0] a, int unsigned sa,
                              logic [ADDR_W-1:0] b, int unsigned sb);
            logic [ADDR_W-1:0] fwd;
            logic [ADDR_W-1:0] back;
            fwd  = b - a;
            back = a - b;
            return (fwd < sa) || (back < sb);
        endfunction

        function t_out_item predict_response(t_in_item it);
            t_out_item         r;
            int unsigned       sz;
            int unsigned       slot;
            int unsigned       lvl;
            int                k;
            bit                hit;
            logic [DATA_W-1:0] d;
            r  = '0;
            sz = (it.size == 0) ? 1 : ((it.size > MAX_SIZE) ? MAX_SIZE : it.size);
            d  = (sz >= MAX_SIZE) ? it.data : it.data & ((64'd1 << (8 * sz)) - 64'd1);
            case (it.op)
                OP_STORE: begin
                    if (fill >= DEPTH) begin
                        wait_level    = DEPTH - 1;
                        wait_pending  = 1'b1;
                        r.status      = ST_FULL;
                        r.drain_until = DU_W'(DEPTH - 1);
                    end else begin
                        slot            = (head + fill) % DEPTH;
                        slot_addr[slot] = it.addr;
                        slot_size[slot] = SIZE_W'(sz);
                        slot_data[slot] = d;
                        fill++;
                        r.status = ST_BUFFERED;
                    end
                end
                OP_LOAD: begin
                    r.status   = ST_READ;
                    r.mem_addr = it.addr;
                    r.mem_size = SIZE_W'(sz);
                    hit        = 1'b0;
                    for (k = int'(fill) - 1; k >= 0 && !hit; k--) begin
                        slot = (head + k) % DEPTH;
                        if (overlaps(it.addr, sz, slot_addr[slot], slot_size[slot])) begin
                            hit = 1'b1;
                            r   = '0;
                            if (slot_addr[slot] == it.addr && slot_size[slot] == sz) begin
                                r.status = ST_FORWARD;
                                r.value  = slot_data[slot];
                            end else begin
                                lvl           = fill - k - 1;
                                wait_level    = lvl;
                                wait_pending  = 1'b1;
                                r.status      = ST_STALL;
                                r.drain_until = DU_W'(lvl);
                            end
                        end
                    end
                end
                OP_FENCE: begin
                    if (fill != 0) begin
                        wait_level   = 0;
                        wait_pending = 1'b1;
                        r.status     = ST_STALL;
                    end else begin
                        r.status = ST_BUFFERED;
                    end
                end
                OP_DRAIN: begin
                    if (fill == 0) begin
                        r.status = ST_ERROR;
                    end else begin
                        r.status   = ST_WRITE;
                        r.mem_addr = slot_addr[head];
                        r.mem_size = slot_size[head];
                        r.value    = slot_data[head];
                        head       = (head + 1) % DEPTH;
                        fill--;
                        if (wait_pending && fill <= wait_level) begin
                            wait_pending = 1'b0;
                            wait_level   = 0;
                            r.wake       = 1'b1;
                        end
                    end
                end
                OP_ATOMIC: begin
                    if (fill != 0) begin
                        r.status = ST_ERROR;
                    end else begin
                        r.status   = ST_WRITE;
                        r.mem_addr = it.addr;
                        r.mem_size = SIZE_W'(sz);
                        r.value    = d;
                    end
                end
                default: begin
                    r.status = ST_ERROR;
                end
            endcase
            return r;
        endfunction

        function void absorb_access(t_in_item it);
            expected_responses.insert(expected_responses.size(), predict_response(it));
        endfunction

        function int field_diff(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                return 1;
            end
            return 0;
        endfunction

        function void check_response(t_out_item got);
            t_out_item want;
            if (expected_responses.size() == 0) begin
                $display("%0t: result item with nothing expected, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_responses.pop_front();
            errors += field_diff("status", want.status, got.status);
            errors += field_diff("mem_addr", want.mem_addr, got.mem_addr);
            errors += field_diff("mem_size", want.mem_size, got.mem_size);
            errors += field_diff("value", want.value, got.value);
            errors += field_diff("drain_until", want.drain_until, got.drain_until);
            errors += field_diff("wake", want.wake, got.wake);
        endfunction
    endclass

    // clock, reset and the two handshake channels
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    // calm phases switch all idling off on both sides
    bit          calm         = 1'b0;
    int unsigned quiet_cycles = 0;

    store_buffer_shadow shadow = new();

    tso_store_buffer_forwarding_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // both handshakes are sampled at the edge, before any nonblocking update lands;
    // the input side is noted first so a same-edge result would still find its entry
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            shadow.absorb_access(in_item);
        end
        if (rst_n && out_valid && out_ready) begin
            shadow.check_response(out_item);
        end
    end

    // watchdog: too many cycles with no item moving on either side
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
            $display("[tso_store_buffer_forwarding_core] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // gap lengths: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (calm) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // operation choice per mix; a small share of undefined opcodes in every mix
    function automatic logic [2:0] pick_op(int mix);
        int roll;
        int c_store;
        int c_load;
        int c_drain;
        int c_fence;
        int c_atomic;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                c_store = 55; c_load = 80; c_drain = 90; c_fence = 94; c_atomic = 97;
            end
            MIX_DRAIN: begin
                c_store = 15; c_load = 40; c_drain = 85; c_fence = 92; c_atomic = 98;
            end
            default: begin
                c_store = 35; c_load = 65; c_drain = 90; c_fence = 95; c_atomic = 99;
            end
        endcase
        if (roll < c_store)  return OP_STORE;
        if (roll < c_load)   return OP_LOAD;
        if (roll < c_drain)  return OP_DRAIN;
        if (roll < c_fence)  return OP_FENCE;
        if (roll < c_atomic) return OP_ATOMIC;
        return 3'($urandom_range(OP_RSVD_5, OP_RSVD_7));
    endfunction

    // present one item and hold it until accepted; valid stays up across back-to-back items
    task automatic send_access(logic [2:0] opcode, logic [ADDR_W-1:0] addr,
                               logic [SIZE_W-1:0] size, logic [DATA_W-1:0] data);
        int       gap;
        t_in_item it;
        gap     = pick_gap();
        it.op   = t_op'(opcode);
        it.addr = addr;
        it.size = size;
        it.data = data;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic run_directed();
        // empty buffer: drain error, plain read at the top address, fence done at once
        send_access(OP_DRAIN, '0, 4'd1, '0);
        send_access(OP_LOAD, 32'hFFFF_FFFF, 4'd8, '0);
        send_access(OP_FENCE, '0, 4'd1, '0);
        // atomic on empty buffer with size 0, so data is cut down to one byte
        send_access(OP_ATOMIC, 32'h8000_0000, 4'd0, '1);
        // undefined opcodes, all other fields at all ones
        send_access(OP_RSVD_5, '1, '1, '1);
        send_access(OP_RSVD_6, '1, '1, '1);
        send_access(OP_RSVD_7, '1, '1, '1);
        // store that wraps past the top of the address space, then a load hitting its tail
        send_access(OP_STORE, 32'hFFFF_FFFE, 4'd4, '1);
        send_access(OP_LOAD, 32'h0000_0001, 4'd1, '0);
        // oversized store clamps to eight bytes
        send_access(OP_STORE, 32'h0000_0100, 4'd15, 64'h0123_4567_89AB_CDEF);
        // exact match on the older entry, then a partial hit on it one entry deep
        send_access(OP_LOAD, 32'hFFFF_FFFE, 4'd4, '0);
        send_access(OP_LOAD, 32'h0000_0000, 4'd2, '0);
        // fence and atomic with entries still queued
        send_access(OP_FENCE, '0, 4'd1, '0);
        send_access(OP_ATOMIC, 32'h0000_0040, 4'd8, '1);
        // fill the rest, then one store too many
        for (int i = 0; i < DEPTH - 2; i++) begin
            send_access(OP_STORE, 32'h0000_1000 + 8 * i, SIZE_W'(i % 8 + 1),
                        {$urandom, $urandom});
        end
        send_access(OP_STORE, 32'h0000_2000, 4'd8, '1);
        // forward from a full buffer, then the drain that releases the full stall
        send_access(OP_LOAD, 32'h0000_0100, 4'd8, '0);
        send_access(OP_DRAIN, '0, 4'd1, '0);
    endtask

    task automatic run_random();
        logic [ADDR_W-1:0]        region;
        logic [ADDR_W-1:0]        addr;
        logic [SIZE_W-1:0]        size;
        logic [2:0]               opcode;
        logic [ADDR_W+SIZE_W-1:0] recent [$];
        int                       mix;
        int                       roll;
        region = '0;
        mix    = MIX_EVEN;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // new mix and address region every few dozen items
            if (n % 64 == 0) begin
                mix    = $urandom_range(MIX_FILL, MIX_EVEN);
                region = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFF0 : ADDR_W'($urandom);
            end
            if (n % 150 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            opcode = pick_op(mix);
            roll   = $urandom_range(0, 99);
            size   = ($urandom_range(0, 4) != 0) ? SIZE_W'(1 << $urandom_range(0, 3))
                                                 : SIZE_W'($urandom_range(0, 15));
            // loads often reuse a recent store's address and size for exact forwarding
            if (opcode == OP_LOAD && recent.size() > 0 && roll < 50) begin
                {addr, size} = recent[$urandom_range(0, recent.size() - 1)];
            end else if (roll < 92) begin
                addr = region + $urandom_range(0, 47);
            end else begin
                addr = $urandom;
            end
            if (opcode == OP_STORE) begin
                recent.insert(recent.size(), {addr, size});
                if (recent.size() > DEPTH) begin
                    void'(recent.pop_front());
                end
            end
            send_access(opcode, addr, size, {$urandom, $urandom});
        end
        calm = 1'b0;
    endtask

    // result side: random stalls, then bursts of ready
    initial begin
        int hold;
        while (!rst_n) @(posedge clk);
        forever begin
            hold = pick_gap();
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // main sequence: reset, directed items, random items, drain out, verdict
    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        run_random();
        in_valid <= 1'b0;
        // one more edge so the last accepted item is surely noted
        @(posedge clk);
        while (shadow.expected_responses.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (shadow.errors == 0) begin
            $display("[tso_store_buffer_forwarding_core] OK");
        end else begin
            $display("[tso_store_buffer_forwarding_core] ERROR");
        end
        $finish;
    end

endmodule
